@@ sv/knpl_pkg.sv @@
// Shared types and constants for the knock pattern loader and player.
// Used by knpl_loader and knock_pattern_loader_player_unit; depends on nothing.
package knpl_pkg;

	// Pattern geometry.
	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = 5;
	localparam int DELAY_W     = 16;
	localparam int BYTE_W      = 8;

	// Register indexes on the configuration port.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_PAUSE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MARKER     = 1'd1;
	localparam int CFG_DATA_W = 16;

	// Reset values.
	localparam logic [DELAY_W-1:0] LOOP_PAUSE_RST    = 16'd100;
	localparam logic [BYTE_W-1:0]  MARKER_RST        = 8'd63;
	localparam logic [DELAY_W-1:0] DEFAULT_DELAY     = 16'd50;
	localparam int                 DEFAULT_ENTRIES   = 3;

	// Operation codes of an input word.
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_BYTE = 1'b1;

	typedef enum logic [2:0] {
		PH_RESTART    = 3'd0,
		PH_PLAY       = 3'd1,
		PH_DELAY      = 3'd2,
		PH_NEXT_LOOP  = 3'd3,
		PH_LOOP_PAUSE = 3'd4
	} player_phase_t;

	typedef enum logic [1:0] {
		PS_SEEK  = 2'd0,
		PS_COUNT = 2'd1,
		PS_LOW   = 2'd2,
		PS_HIGH  = 2'd3
	} parse_phase_t;

	// Status from the loader to the player.
	typedef struct packed {
		logic               commit;
		logic [CNT_W-1:0]   count_next;
		logic [CNT_W-1:0]   count_now;
		logic [DELAY_W-1:0] rd_data;
	} ld_status_t;

endpackage

@@ sv/knpl_loader.sv @@
// Packet byte parser with the two-bank pattern store and bank entry counts.
// Depends on knpl_pkg.
module knpl_loader (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           byte_en,
	input  logic [knpl_pkg::BYTE_W-1:0]    rx_byte,
	input  logic                           last_byte,
	input  logic [knpl_pkg::BYTE_W-1:0]    marker,
	input  logic [knpl_pkg::IDX_W-1:0]     rd_idx,
	output knpl_pkg::ld_status_t           status
);

	localparam logic [knpl_pkg::CNT_W-1:0]  MAX_CNT  = knpl_pkg::CNT_W'(knpl_pkg::MAX_ENTRIES);
	localparam logic [knpl_pkg::BYTE_W-1:0] MAX_BYTE = knpl_pkg::BYTE_W'(knpl_pkg::MAX_ENTRIES);

	knpl_pkg::parse_phase_t parse_q, parse_d;
	logic [knpl_pkg::CNT_W-1:0]   idx_q, idx_d;
	logic [knpl_pkg::BYTE_W-1:0]  hold_q, hold_d;
	logic                         act_q;
	logic [knpl_pkg::CNT_W-1:0]   cnt_q [2];
	logic [knpl_pkg::DELAY_W-1:0] store_q [2][knpl_pkg::MAX_ENTRIES];

	logic                         stg;
	logic [knpl_pkg::CNT_W-1:0]   cnt_stg_d;
	logic                         cnt_wr;
	logic                         clr_en;
	logic                         wr_en;
	logic                         commit;

	assign stg = ~act_q;

	// Parser next state, store write controls and commit.
	always_comb begin
		parse_d   = parse_q;
		idx_d     = idx_q;
		hold_d    = hold_q;
		cnt_stg_d = cnt_q[stg];
		cnt_wr    = 1'b0;
		clr_en    = 1'b0;
		wr_en     = 1'b0;
		commit    = 1'b0;
		if (byte_en) begin
			case (parse_q)
				knpl_pkg::PS_SEEK: begin
					if (rx_byte == marker) begin
						clr_en    = 1'b1;
						cnt_stg_d = '0;
						cnt_wr    = 1'b1;
						parse_d   = knpl_pkg::PS_COUNT;
					end
				end
				knpl_pkg::PS_COUNT: begin
					cnt_stg_d = (rx_byte > MAX_BYTE) ? MAX_CNT : rx_byte[knpl_pkg::CNT_W-1:0];
					cnt_wr    = 1'b1;
					idx_d     = '0;
					parse_d   = knpl_pkg::PS_LOW;
				end
				knpl_pkg::PS_LOW: begin
					if (idx_q < cnt_q[stg] && idx_q < MAX_CNT) begin
						hold_d  = rx_byte;
						parse_d = knpl_pkg::PS_HIGH;
					end
				end
				knpl_pkg::PS_HIGH: begin
					wr_en   = (idx_q < MAX_CNT);
					idx_d   = idx_q + 1'b1;
					parse_d = knpl_pkg::PS_LOW;
				end
				default: begin
					parse_d = knpl_pkg::PS_SEEK;
				end
			endcase
			// The final byte of a packet returns to seeking and commits if a marker was seen.
			if (last_byte) begin
				commit  = (parse_d != knpl_pkg::PS_SEEK);
				parse_d = knpl_pkg::PS_SEEK;
			end
		end
	end

	// Parser registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q <= knpl_pkg::PS_SEEK;
			idx_q   <= '0;
			hold_q  <= '0;
			act_q   <= 1'b0;
			cnt_q[0] <= knpl_pkg::CNT_W'(knpl_pkg::DEFAULT_ENTRIES);
			cnt_q[1] <= '0;
		end else begin
			parse_q <= parse_d;
			idx_q   <= idx_d;
			hold_q  <= hold_d;
			if (cnt_wr) begin
				cnt_q[stg] <= cnt_stg_d;
			end
			if (commit) begin
				act_q <= stg;
			end
		end
	end

	// Pattern store: marker clears the whole staging bank, a high byte writes one entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < 2; b++) begin
				for (int e = 0; e < knpl_pkg::MAX_ENTRIES; e++) begin
					store_q[b][e] <= (b == 0 && e < knpl_pkg::DEFAULT_ENTRIES) ?
						knpl_pkg::DEFAULT_DELAY : '0;
				end
			end
		end else if (clr_en) begin
			for (int e = 0; e < knpl_pkg::MAX_ENTRIES; e++) begin
				store_q[stg][e] <= '0;
			end
		end else if (wr_en) begin
			store_q[stg][idx_q[knpl_pkg::IDX_W-1:0]] <= {rx_byte, hold_q};
		end
	end

	// Status toward the player.
	always_comb begin
		status.commit     = commit;
		status.count_now  = cnt_q[act_q];
		status.count_next = commit ? cnt_stg_d : cnt_q[act_q];
		status.rd_data    = store_q[act_q][rd_idx];
	end

endmodule

@@ sv/knock_pattern_loader_player_unit.sv @@
// Top level of the knock pattern loader and player: player state machine,
// configuration registers and result register. Depends on knpl_pkg and knpl_loader.

// Each accepted word is either a timer tick (operation 0) or one received
// packet byte (operation 1), and produces exactly one result word in the next
// cycle: knock on ticks, pattern_loaded on the final byte of a packet that
// carried the marker, and the entry count of the active pattern. The block
// takes one word per clock cycle; all the work for a word fits between the
// input handshake and the single result register, so the only limit on rate
// is the result register, and in_stall is raised only while a result is held
// there and out_stall is high. Configuration writes are taken at any edge
// with cfg_we high and should be made while no word is in flight.
module knock_pattern_loader_player_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration port.
	input  logic                               cfg_we,
	input  logic [knpl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [knpl_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Input channel.
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               operation,
	input  logic [knpl_pkg::BYTE_W-1:0]        rx_byte,
	input  logic                               last_byte,
	// Output channel.
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               knock,
	output logic                               pattern_loaded,
	output logic [knpl_pkg::CNT_W-1:0]         loaded_count
);

	localparam logic [knpl_pkg::CNT_W-1:0] MAX_CNT = knpl_pkg::CNT_W'(knpl_pkg::MAX_ENTRIES);

	logic [knpl_pkg::DELAY_W-1:0] loop_pause_q;
	logic [knpl_pkg::BYTE_W-1:0]  marker_q;

	knpl_pkg::player_phase_t      phase_q, phase_d;
	logic [knpl_pkg::CNT_W-1:0]   pos_q, pos_d;
	logic [knpl_pkg::DELAY_W-1:0] timer_q, timer_d;
	logic                         knock_d;

	logic                         accept;
	logic                         tick_en;
	logic                         byte_en;
	knpl_pkg::ld_status_t         ld_status;

	logic                         out_valid_q;
	logic                         knock_q;
	logic                         loaded_q;
	logic [knpl_pkg::CNT_W-1:0]   count_q;

	// Input handshake: a word is taken unless a held result is stalled.
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign tick_en  = accept & (operation == knpl_pkg::OP_TICK);
	assign byte_en  = accept & (operation == knpl_pkg::OP_BYTE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_pause_q <= knpl_pkg::LOOP_PAUSE_RST;
			marker_q     <= knpl_pkg::MARKER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				knpl_pkg::CFG_LOOP_PAUSE: loop_pause_q <= cfg_data;
				knpl_pkg::CFG_MARKER:     marker_q     <= cfg_data[knpl_pkg::BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	knpl_loader u_loader (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (byte_en),
		.rx_byte   (rx_byte),
		.last_byte (last_byte),
		.marker    (marker_q),
		.rd_idx    (pos_q[knpl_pkg::IDX_W-1:0]),
		.status    (ld_status)
	);

	// Player next state; a commit forces the loop pause to start over.
	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		timer_d = timer_q;
		knock_d = 1'b0;
		if (tick_en) begin
			case (phase_q)
				knpl_pkg::PH_PLAY: begin
					knock_d = 1'b1;
					if (pos_q >= ld_status.count_now || pos_q >= MAX_CNT) begin
						phase_d = knpl_pkg::PH_NEXT_LOOP;
					end else begin
						timer_d = ld_status.rd_data;
						pos_d   = pos_q + 1'b1;
						phase_d = knpl_pkg::PH_DELAY;
					end
				end
				knpl_pkg::PH_DELAY: begin
					if (timer_q <= knpl_pkg::DELAY_W'(1)) begin
						timer_d = '0;
						phase_d = knpl_pkg::PH_PLAY;
					end else begin
						timer_d = timer_q - 1'b1;
					end
				end
				knpl_pkg::PH_NEXT_LOOP: begin
					timer_d = loop_pause_q;
					phase_d = knpl_pkg::PH_LOOP_PAUSE;
				end
				knpl_pkg::PH_LOOP_PAUSE: begin
					if (timer_q <= knpl_pkg::DELAY_W'(1)) begin
						timer_d = '0;
						phase_d = knpl_pkg::PH_RESTART;
					end else begin
						timer_d = timer_q - 1'b1;
					end
				end
				default: begin
					pos_d   = '0;
					phase_d = knpl_pkg::PH_PLAY;
				end
			endcase
		end else if (ld_status.commit) begin
			phase_d = knpl_pkg::PH_NEXT_LOOP;
		end
	end

	// Player state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= knpl_pkg::PH_RESTART;
			pos_q   <= '0;
			timer_q <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			timer_q <= timer_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			knock_q  <= knock_d;
			loaded_q <= ld_status.commit;
			count_q  <= ld_status.count_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign knock          = knock_q;
	assign pattern_loaded = loaded_q;
	assign loaded_count   = count_q;

`ifndef NO_ASSERTIONS
	// An accepted word always shows up as a result on the next cycle.
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted word produced no result");

	// A tick never commits a pattern and a byte never knocks.
	a_knock_xor_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(knock && pattern_loaded))
		else $error("knock and pattern_loaded together");

	// The active entry count never exceeds the pattern capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (loaded_count <= MAX_CNT))
		else $error("loaded_count out of range");

	// A commit sends the player to the next-loop phase, which restarts the loop pause, on the next cycle.
	a_commit_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ld_status.commit |=> (phase_q == knpl_pkg::PH_NEXT_LOOP))
		else $error("commit did not restart the loop pause");
`endif

endmodule
